/* rtl/md2_pkg.sv */
// shared constants, types and the s-box table of the md2 digest engine
package md2_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int STATE_BYTES = 48;
  localparam int ROUNDS      = 18;
  localparam int LANES       = 8;
  localparam int GROUPS      = STATE_BYTES / LANES;

  localparam int IN_QUEUE_DEPTH  = 4;
  localparam int OUT_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } result_t;

  localparam logic [7:0] SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

/* rtl/md2_hash_engine.sv */
// md2 digest engine top level: input queue, compression core and result queue
//
// Input channel: push/full with data_byte, has_byte and is_last; one message
// byte per transfer. An item with neither a byte nor is_last does nothing.
// Result channel: empty/pop; each digest gives four transfers of digest_word
// (state bytes little-endian), word_index 0..3, last_word on the fourth.
// Items enter a short queue in front of the core, so the source keeps pushing
// while a block is being compressed, as long as the queue has room.
// Each byte is absorbed in turn; every sixteenth byte starts a
// compression of 18 rounds over the 48-byte state, eight chained s-box
// lookups a cycle; throughput is bounded by that s-box chain, and the core
// takes no byte from the queue while a block is compressed. After an is_last
// item (and the compression of a block it fills): n padding bytes (1..16),
// a compression, the checksum block load, a compression, then four words.
// The words sit in a result queue; when the receiver stalls and that queue
// fills, the core waits and the input queue backs up into full.
// Reset clears both queues, the hash state and the checksum; after the last
// word the state returns to its reset value and a new message begins.
module md2_hash_engine #(
  parameter int IN_DEPTH  = md2_pkg::IN_QUEUE_DEPTH,
  parameter int OUT_DEPTH = md2_pkg::OUT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  md2_pkg::item_t   q_item;
  logic             q_empty;
  logic             q_pop;
  logic             res_push;
  logic             res_full;
  md2_pkg::result_t res_data;
  md2_pkg::result_t res_head;
  logic [$bits(md2_pkg::result_t)-1:0] res_rdata;

  md2_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .is_last   (is_last),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .q_empty   (q_empty)
  );

  md2_core u_core (
    .clk      (clk),
    .rst      (rst),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full)
  );

  md2_fifo #(
    .WIDTH ($bits(md2_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_head    = md2_pkg::result_t'(res_rdata);
  assign digest_word = res_head.digest_word;
  assign word_index  = res_head.word_index;
  assign last_word   = res_head.last_word;

endmodule

/* rtl/md2_fifo.sv */
// small first-in first-out queue built from registers
module md2_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = md2_pkg::IN_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  // depth of two or more
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/md2_front.sv */
// front end: filters empty items and queues the rest for the core
module md2_front #(
  parameter int DEPTH = md2_pkg::IN_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    data_byte,
  input  logic          has_byte,
  input  logic          is_last,
  input  logic          q_pop,
  output md2_pkg::item_t q_item,
  output logic          q_empty
);

  md2_pkg::item_t in_item;
  logic [$bits(md2_pkg::item_t)-1:0] q_rdata;
  logic keep;

  // an item with neither a byte nor an end mark has no effect at all
  assign keep    = has_byte || is_last;
  assign in_item = '{data_byte: data_byte, has_byte: has_byte, is_last: is_last};
  assign q_item  = md2_pkg::item_t'(q_rdata);

  md2_fifo #(
    .WIDTH ($bits(md2_pkg::item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (in_item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

endmodule

/* rtl/md2_core.sv */
// back end: absorbs bytes, pads, runs the compression rounds and emits the digest
module md2_core (
  input  logic             clk,
  input  logic             rst,
  input  md2_pkg::item_t   q_item,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             res_push,
  output md2_pkg::result_t res_data,
  input  logic             res_full
);

  localparam int SB    = md2_pkg::STATE_BYTES;
  localparam int BB    = md2_pkg::BLOCK_BYTES;
  localparam int LN    = md2_pkg::LANES;
  localparam int FILL_W = $clog2(md2_pkg::BLOCK_BYTES);
  localparam int PAD_W  = FILL_W + 1;
  localparam int GRP_W  = $clog2(md2_pkg::GROUPS);
  localparam int RND_W  = $clog2(md2_pkg::ROUNDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_CKS,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_CKS
  } phase_t;

  state_t            state;
  phase_t            phase;
  logic [7:0]        hs [SB];
  logic [7:0]        cks [BB];
  logic [7:0]        carry;
  logic [FILL_W-1:0] fill;
  logic [PAD_W-1:0]  pad_val;
  logic              ending;
  logic [GRP_W-1:0]  grp;
  logic [RND_W-1:0]  rnd;
  logic [7:0]        t;
  logic [1:0]        wcnt;

  logic [7:0]        ab;
  logic [7:0]        newc;
  logic [7:0]        hs_abs [SB];
  logic [7:0]        cks_abs [BB];
  logic [7:0]        lane [LN];
  logic [7:0]        hs_cmp [SB];
  logic [7:0]        t_chain;
  logic [PAD_W-1:0]  fill_inc;
  logic              fill_last;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign res_push = (state == S_OUT) && !res_full;
  assign res_data = '{digest_word: {hs[3], hs[2], hs[1], hs[0]},
                      word_index:  wcnt,
                      last_word:   (wcnt == 2'd3)};

  assign fill_inc  = {1'b0, fill} + 1'b1;
  assign fill_last = (fill == FILL_W'(BB - 1));

  // absorb one byte: block 0 rotates so byte 0 is always the current slot,
  // blocks 1 and 2 and the checksum shift in at the tail
  always_comb begin
    ab = (state == S_PAD) ? 8'(pad_val) : q_item.data_byte;
    newc = cks[0] ^ md2_pkg::SBOX[ab ^ carry];
    for (int i = 0; i < BB - 1; i++) begin
      hs_abs[i]          = hs[i + 1];
      hs_abs[BB + i]     = hs[BB + i + 1];
      hs_abs[2 * BB + i] = hs[2 * BB + i + 1];
      cks_abs[i]         = cks[i + 1];
    end
    hs_abs[BB - 1]     = hs[0];
    hs_abs[2 * BB - 1] = ab;
    hs_abs[SB - 1]     = ab ^ hs[0];
    cks_abs[BB - 1]    = newc;
  end

  // one group of s-box steps; the state rotates so the group sits at the head
  always_comb begin
    t_chain = t;
    for (int j = 0; j < LN; j++) begin
      lane[j] = hs[j] ^ md2_pkg::SBOX[t_chain];
      t_chain = lane[j];
    end
    for (int i = 0; i < SB - LN; i++) begin
      hs_cmp[i] = hs[i + LN];
    end
    for (int j = 0; j < LN; j++) begin
      hs_cmp[SB - LN + j] = lane[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_DATA;
      hs      <= '{default: '0};
      cks     <= '{default: '0};
      carry   <= '0;
      fill    <= '0;
      pad_val <= '0;
      ending  <= 1'b0;
      grp     <= '0;
      rnd     <= '0;
      t       <= '0;
      wcnt    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_item.has_byte) begin
              hs    <= hs_abs;
              cks   <= cks_abs;
              carry <= newc;
              fill  <= FILL_W'(fill_inc);
              if (fill_last) begin
                state  <= S_COMP;
                phase  <= PH_DATA;
                ending <= q_item.is_last;
                grp    <= '0;
                rnd    <= '0;
                t      <= '0;
              end else if (q_item.is_last) begin
                state   <= S_PAD;
                pad_val <= PAD_W'(BB) - fill_inc;
              end
            end else begin
              // end mark with no byte
              state   <= S_PAD;
              pad_val <= PAD_W'(BB) - {1'b0, fill};
            end
          end
        end
        S_PAD: begin
          hs    <= hs_abs;
          cks   <= cks_abs;
          carry <= newc;
          fill  <= FILL_W'(fill_inc);
          if (fill_last) begin
            state <= S_COMP;
            phase <= PH_PAD;
            grp   <= '0;
            rnd   <= '0;
            t     <= '0;
          end
        end
        S_COMP: begin
          hs <= hs_cmp;
          if (grp == GRP_W'(md2_pkg::GROUPS - 1)) begin
            grp <= '0;
            t   <= lane[LN - 1] + 8'(rnd);
            if (rnd == RND_W'(md2_pkg::ROUNDS - 1)) begin
              rnd <= '0;
              case (phase)
                PH_DATA: begin
                  if (ending) begin
                    state   <= S_PAD;
                    pad_val <= PAD_W'(BB);
                  end else begin
                    state <= S_IDLE;
                  end
                end
                PH_PAD: begin
                  state <= S_CKS;
                end
                PH_CKS: begin
                  state <= S_OUT;
                  wcnt  <= '0;
                end
                default: begin
                  state <= S_IDLE;
                end
              endcase
            end else begin
              rnd <= rnd + 1'b1;
            end
          end else begin
            grp <= grp + 1'b1;
            t   <= lane[LN - 1];
          end
        end
        S_CKS: begin
          for (int i = 0; i < BB; i++) begin
            hs[BB + i]     <= cks[i];
            hs[2 * BB + i] <= cks[i] ^ hs[i];
          end
          state <= S_COMP;
          phase <= PH_CKS;
          grp   <= '0;
          rnd   <= '0;
          t     <= '0;
        end
        S_OUT: begin
          if (!res_full) begin
            wcnt <= wcnt + 1'b1;
            if (wcnt == 2'd3) begin
              state  <= S_IDLE;
              hs     <= '{default: '0};
              cks    <= '{default: '0};
              carry  <= '0;
              fill   <= '0;
              ending <= 1'b0;
            end else begin
              // next word moves to the head
              for (int i = 0; i < SB - 4; i++) begin
                hs[i] <= hs[i + 4];
              end
              for (int i = SB - 4; i < SB; i++) begin
                hs[i] <= '0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cks_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_CKS || state == S_OUT) |-> (fill == '0))
    else $error("checksum block or output with a partly filled block");

  a_comp_counters: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP) |->
      (rnd < RND_W'(md2_pkg::ROUNDS)) && (grp < GRP_W'(md2_pkg::GROUPS)))
    else $error("round or group counter out of range");

  a_clear_after_digest: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.last_word) |=>
      (state == S_IDLE) && (fill == '0) && (carry == '0))
    else $error("state not cleared after the final digest word");

  a_out_after_cks: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && ($past(state) != S_OUT)) |->
      ($past(phase) == PH_CKS) && (wcnt == 2'd0))
    else $error("digest output not preceded by the checksum block");

endmodule
